/* design/lpps_pkg.sv */
// shared types and constants for the laser point packet serializer
// no dependencies; used by every module of the block
package lpps_pkg;

  localparam int IN_W      = 18;
  localparam int WORD_W    = 16;
  localparam int NUM_ENC   = 8;
  localparam int NUM_COORD = 2;
  localparam int QDEPTH    = 2;

  localparam logic [7:0]  HDR_ID    = 8'h64;
  localparam logic [15:0] CTRL_RATE = 16'h8000;

  // byte positions inside one point's byte stream
  localparam logic [4:0] IDX_HDR_ID   = 5'd0;
  localparam logic [4:0] IDX_CNT_LO   = 5'd1;
  localparam logic [4:0] IDX_CNT_HI   = 5'd2;
  localparam logic [4:0] IDX_FIRST_PT = 5'd5;
  localparam logic [4:0] IDX_LAST     = 5'd22;

  // configuration register indexes
  localparam logic CFG_COORD_SCALE   = 1'b0;
  localparam logic CFG_CHANNEL_SCALE = 1'b1;

  typedef struct packed {
    logic                            start;
    logic [WORD_W-1:0]               count;
    logic                            rate;
    logic                            last_point;
    logic [NUM_ENC-1:0][WORD_W-1:0]  enc;
  } pt_rec_t;

endpackage

/* design/lpps_front.sv */
// front end: takes points, tracks the packet counter and encodes the eight
// sample words with one shared multiplier; depends on lpps_pkg
module lpps_front #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_start_packet,
  input  logic [15:0]                    in_point_count,
  input  logic                           in_rate_change,
  input  logic [lpps_pkg::NUM_ENC-1:0][lpps_pkg::IN_W-1:0] in_samples,
  input  logic [14:0]                    coord_scale,
  input  logic [15:0]                    channel_scale,
  output logic                           q_push,
  output lpps_pkg::pt_rec_t              q_rec,
  input  logic                           q_full
);

  localparam int SW = (FRACTION_BITS + 2 > 19) ? FRACTION_BITS + 2 : 19;
  localparam int MW = SW - 1;
  localparam int PW = MW + 16;
  localparam int KW = $clog2(lpps_pkg::NUM_ENC);
  localparam logic [SW-1:0] ONE  = SW'(1) << FRACTION_BITS;
  localparam logic [PW:0]   HALF = (PW + 1)'(1) << (FRACTION_BITS - 1);
  localparam logic [KW-1:0] K_LAST = KW'(lpps_pkg::NUM_ENC - 1);

  // returns {negative, clamped magnitude}
  function automatic logic [MW:0] clamp_mag(input logic [lpps_pkg::IN_W-1:0] raw,
                                            input logic coord);
    logic signed [SW-1:0] sv;
    logic signed [SW-1:0] one_s;
    logic signed [SW-1:0] neg_v;
    logic [MW:0]          res;
    sv    = {{(SW - lpps_pkg::IN_W){raw[lpps_pkg::IN_W-1]}}, raw};
    one_s = $signed(ONE);
    neg_v = -sv;
    if (coord) begin
      if (sv > one_s || sv < -one_s) res = {sv[SW-1], ONE[MW-1:0]};
      else if (sv[SW-1])             res = {1'b1, neg_v[MW-1:0]};
      else                           res = {1'b0, sv[MW-1:0]};
    end else begin
      if (sv[SW-1])         res = '0;
      else if (sv > one_s)  res = {1'b0, ONE[MW-1:0]};
      else                  res = {1'b0, sv[MW-1:0]};
    end
    return res;
  endfunction

  logic                busy_r, busy_nxt;
  logic                issue_r, issue_nxt;
  logic                pv_r, pv_nxt;
  logic                done_r, done_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [15:0]         pl_r, pl_nxt;
  logic [KW-1:0]       pk_r;
  logic [PW-1:0]       prod_r;
  logic [MW-1:0]       mag_r [lpps_pkg::NUM_ENC];
  logic [lpps_pkg::NUM_COORD-1:0] neg_r;
  lpps_pkg::pt_rec_t   rec_r, rec_nxt;

  logic                in_acc;
  logic                push_ok;
  logic [15:0]         base;
  logic [15:0]         scale_sel;
  logic [PW:0]         sum;
  logic [PW:0]         qf;
  logic [15:0]         q16;
  logic [15:0]         enc_val;
  logic                is_coord;

  assign push_ok = done_r && !q_full;
  assign in_full = busy_r && !push_ok;
  assign in_acc  = in_push && !in_full;
  assign q_push  = push_ok;
  assign q_rec   = rec_r;

  assign base      = in_start_packet ? in_point_count : pl_r;
  assign scale_sel = (k_r < KW'(lpps_pkg::NUM_COORD)) ? {1'b0, coord_scale} : channel_scale;

  // rounding of the registered product
  assign is_coord = pk_r < KW'(lpps_pkg::NUM_COORD);
  assign sum      = {1'b0, prod_r} + HALF;
  assign qf       = sum >> FRACTION_BITS;
  assign q16      = qf[15:0];

  always_comb begin
    if (is_coord) begin
      enc_val = neg_r[pk_r[0]] ? 16'(-q16) : q16;
    end else if (qf > (PW + 1)'(channel_scale)) begin
      enc_val = channel_scale;
    end else begin
      enc_val = q16;
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    issue_nxt = issue_r;
    done_nxt  = done_r;
    k_nxt     = k_r;
    pl_nxt    = pl_r;
    rec_nxt   = rec_r;
    pv_nxt    = issue_r;
    if (push_ok) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b0;
    end
    if (in_acc) begin
      busy_nxt           = 1'b1;
      issue_nxt          = 1'b1;
      k_nxt              = '0;
      done_nxt           = 1'b0;
      rec_nxt.start      = in_start_packet;
      rec_nxt.count      = in_point_count;
      rec_nxt.rate       = in_start_packet && in_rate_change;
      rec_nxt.last_point = base <= 16'd1;
      pl_nxt             = (base == 16'd0) ? 16'd0 : base - 16'd1;
    end
    if (issue_r) begin
      if (k_r == K_LAST) issue_nxt = 1'b0;
      else               k_nxt     = k_r + KW'(1);
    end
    if (pv_r) begin
      rec_nxt.enc[pk_r] = enc_val;
      if (pk_r == K_LAST) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      pv_r    <= 1'b0;
      done_r  <= 1'b0;
      k_r     <= '0;
      pl_r    <= '0;
    end else begin
      busy_r  <= busy_nxt;
      issue_r <= issue_nxt;
      pv_r    <= pv_nxt;
      done_r  <= done_nxt;
      k_r     <= k_nxt;
      pl_r    <= pl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    logic [MW:0] cm;
    rec_r <= rec_nxt;
    if (issue_r) begin
      prod_r <= PW'(mag_r[k_r]) * PW'(scale_sel);
      pk_r   <= k_r;
    end
    if (in_acc) begin
      for (int i = 0; i < lpps_pkg::NUM_ENC; i++) begin
        cm        = clamp_mag(in_samples[i], i < lpps_pkg::NUM_COORD);
        mag_r[i] <= cm[MW-1:0];
        if (i < lpps_pkg::NUM_COORD) neg_r[i] <= cm[MW];
      end
    end
  end

`ifndef SYNTHESIS
  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r |-> busy_r && !done_r)
    else $error("multiplier issuing outside a busy point");
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !issue_r && !pv_r)
    else $error("point marked done while words still pending");
`endif

endmodule

/* design/lpps_queue.sv */
// short queue of encoded point requests between front and back
// depends on lpps_pkg for the entry type and depth
module lpps_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lpps_pkg::pt_rec_t din,
  output logic              full,
  input  logic              pop,
  output lpps_pkg::pt_rec_t dout,
  output logic              empty
);

  localparam int PTR_W = $clog2(lpps_pkg::QDEPTH);
  localparam int CNT_W = $clog2(lpps_pkg::QDEPTH + 1);

  lpps_pkg::pt_rec_t ent_r [lpps_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign full    = cnt_r == CNT_W'(lpps_pkg::QDEPTH);
  assign empty   = cnt_r == '0;
  assign dout    = ent_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PTR_W'(lpps_pkg::QDEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      if (do_pop)  rd_r <= (rd_r == PTR_W'(lpps_pkg::QDEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_r] <= din;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(lpps_pkg::QDEPTH))
    else $error("queue count past depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

/* design/lpps_back.sv */
// back end: walks each encoded point byte by byte into the output register
// depends on lpps_pkg for the entry type and byte positions
module lpps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lpps_pkg::pt_rec_t q_rec,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_data_byte,
  output logic              out_last_of_point,
  output logic              out_end_of_packet
);

  lpps_pkg::pt_rec_t cur_r;
  logic              active_r;
  logic [4:0]        idx_r;
  logic              ov_r;
  logic [7:0]        byte_r;
  logic              lop_r, eop_r;

  logic              adv, take, at_last, load_new;
  logic [4:0]        j;
  logic [3:0]        w;
  logic [15:0]       word;
  logic [7:0]        byte_val;

  assign adv      = !ov_r || out_pop;
  assign take     = adv && active_r;
  assign at_last  = idx_r == lpps_pkg::IDX_LAST;
  assign load_new = !q_empty && (!active_r || (take && at_last));
  assign q_pop    = load_new;

  assign j = idx_r - lpps_pkg::IDX_FIRST_PT;
  assign w = j[4:1];

  always_comb begin
    if (w == 4'd0) begin
      word = cur_r.rate ? lpps_pkg::CTRL_RATE : 16'd0;
    end else begin
      word = cur_r.enc[3'(w - 4'd1)];
    end
  end

  always_comb begin
    unique case (idx_r)
      lpps_pkg::IDX_HDR_ID: byte_val = lpps_pkg::HDR_ID;
      lpps_pkg::IDX_CNT_LO: byte_val = cur_r.count[7:0];
      lpps_pkg::IDX_CNT_HI: byte_val = cur_r.count[15:8];
      default: begin
        // flags word of the header is zero
        if (idx_r < lpps_pkg::IDX_FIRST_PT) byte_val = 8'd0;
        else                                byte_val = j[0] ? word[15:8] : word[7:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (load_new) begin
        active_r <= 1'b1;
        idx_r    <= q_rec.start ? lpps_pkg::IDX_HDR_ID : lpps_pkg::IDX_FIRST_PT;
      end else if (take && at_last) begin
        active_r <= 1'b0;
      end else if (take) begin
        idx_r <= idx_r + 5'd1;
      end
      if (take)         ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_new) cur_r <= q_rec;
    if (take) begin
      byte_r <= byte_val;
      lop_r  <= at_last;
      eop_r  <= at_last && cur_r.last_point;
    end
  end

  assign out_empty         = !ov_r;
  assign out_data_byte     = byte_r;
  assign out_last_of_point = lop_r;
  assign out_end_of_packet = eop_r;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> idx_r <= lpps_pkg::IDX_LAST)
    else $error("byte index past end of point");
  a_eop_lop: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && eop_r |-> lop_r)
    else $error("end of packet without end of point");
`endif

endmodule

/* design/laser_point_packet_serializer.sv */
// Laser point packet serializer. Each accepted point leaves as 18 bytes (nine
// little-endian words: control, x, y, red, green, blue, intensity, user_one,
// user_two), or 23 bytes when it opens a packet and carries the 5-byte header.
// Bytes come out at one per cycle while points are queued and out_pop drains
// each byte as it shows, a rate set by the single byte output register.
// The front end encodes one point at a time with one shared multiplier and
// a two-entry queue lets it run ahead of the byte stream. Scales are written
// through cfg_ while the block is idle; this binds the user, as the block
// itself does not enforce it; cfg_ready is always high.
module laser_point_packet_serializer #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_start_packet,
  input  logic [15:0]        in_point_count,
  input  logic               in_rate_change,
  input  logic signed [17:0] in_x,
  input  logic signed [17:0] in_y,
  input  logic signed [17:0] in_red,
  input  logic signed [17:0] in_green,
  input  logic signed [17:0] in_blue,
  input  logic signed [17:0] in_intensity,
  input  logic signed [17:0] in_user_one,
  input  logic signed [17:0] in_user_two,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_data_byte,
  output logic               out_last_of_point,
  output logic               out_end_of_packet,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [14:0] coord_scale_r;
  logic [15:0] channel_scale_r;

  logic [lpps_pkg::NUM_ENC-1:0][lpps_pkg::IN_W-1:0] samples;
  logic              q_push, q_full, q_pop, q_empty;
  lpps_pkg::pt_rec_t q_din, q_dout;

  assign cfg_ready = 1'b1;
  assign samples   = {in_user_two, in_user_one, in_intensity, in_blue,
                      in_green, in_red, in_y, in_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_scale_r   <= 15'd32767;
      channel_scale_r <= 16'd65535;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpps_pkg::CFG_COORD_SCALE:   coord_scale_r   <= cfg_data[14:0];
        lpps_pkg::CFG_CHANNEL_SCALE: channel_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lpps_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_start_packet (in_start_packet),
    .in_point_count  (in_point_count),
    .in_rate_change  (in_rate_change),
    .in_samples      (samples),
    .coord_scale     (coord_scale_r),
    .channel_scale   (channel_scale_r),
    .q_push          (q_push),
    .q_rec           (q_din),
    .q_full          (q_full)
  );

  lpps_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  lpps_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rec             (q_dout),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_data_byte     (out_data_byte),
    .out_last_of_point (out_last_of_point),
    .out_end_of_packet (out_end_of_packet)
  );

endmodule
